// ===== hw/rtl/ilie_pkg.sv =====
`default_nettype none

package ilie_pkg;

	// Width of the position field of an input item.
	localparam int POS_W = 5;
	// Width of the data fields of both items.
	localparam int DATA_W = 32;
	// Width of the entry count of a result item.
	localparam int CNT_OUT_W = 5;

	// Actions carried by an input item.
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_ERASE  = 2'd1,
		ACT_READ   = 2'd2,
		ACT_WRITE  = 2'd3
	} action_t;

	// Status codes carried by a result item.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Input item.
	typedef struct packed {
		action_t             action;
		logic [POS_W-1:0]    position;
		logic [DATA_W-1:0]   word_in;
	} req_item_t;

	// Result item.
	typedef struct packed {
		logic [DATA_W-1:0]    word_out;
		logic [CNT_OUT_W-1:0] entry_count;
		status_t              status;
	} rsp_item_t;

	// Operation broadcast to every cell of the row; at most one bit is set,
	// and only for an accepted item that passed its checks.
	typedef struct packed {
		logic ins;
		logic ers;
		logic wr;
	} cell_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ilie_cell.sv =====
`default_nettype none

module ilie_cell #(
	parameter int IDX_W      = 5,
	parameter int INDEX      = 0,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire ilie_pkg::cell_op_t    op,
	input  wire logic [IDX_W-1:0]      position,
	input  wire logic [WORD_WIDTH-1:0] word_in,
	input  wire logic [WORD_WIDTH-1:0] prev_word,
	input  wire logic [WORD_WIDTH-1:0] next_word,
	output logic      [WORD_WIDTH-1:0] word,
	output logic      [WORD_WIDTH-1:0] pick
);
	import ilie_pkg::*;

	localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

	logic [WORD_WIDTH-1:0] word_q;
	logic                  at_pos;
	logic                  above_pos;

	// Where this cell stands relative to the addressed position.
	assign at_pos    = (IDX == position);
	assign above_pos = (IDX > position);

	// The entry moves up on insert, down on erase, or takes the new word.
	// Cells beyond the count may take stale words; those are never read.
	always_ff @(posedge clk) begin
		if (op.ins && at_pos) begin
			word_q <= word_in;
		end else if (op.ins && above_pos) begin
			word_q <= prev_word;
		end else if (op.ers && (at_pos || above_pos)) begin
			word_q <= next_word;
		end else if (op.wr && at_pos) begin
			word_q <= word_in;
		end
	end

	assign word = word_q;

	// Only the addressed cell offers its word to the read bus.
	assign pick = at_pos ? word_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_list_insert_erase.sv =====
`default_nettype none

// Ordered list of up to DEPTH words held in a row of cells, one entry per
// cell, with insert, erase, read and write at a position. An item is taken
// in every cycle unless req_stall is high: the whole row shifts or holds in
// parallel in the cycle the item is accepted, and the result appears in the
// output register in the next cycle. The result register frees the input side
// at once when the result is taken, so req_stall is high only while a finished
// result waits under rsp_stall. Every result carries the entry count after the
// action; errors (position out of range, or insert into a full list) change
// nothing. The contents of an entry are defined only once an insert or a write
// has put a word there.
module indexed_list_insert_erase #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire ilie_pkg::req_item_t   req_item,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output ilie_pkg::rsp_item_t        rsp_item
);
	import ilie_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_nxt;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_item_q;
	rsp_item_t             rsp_nxt;
	logic                  accept;
	logic [CMPW-1:0]       pos_x;
	logic [CMPW-1:0]       cnt_x;
	logic                  ins_range;
	logic                  other_range;
	logic                  full;
	logic                  ins_ok;
	logic                  ers_ok;
	logic                  rd_ok;
	logic                  wr_ok;
	cell_op_t              op;
	logic [WORD_WIDTH-1:0] word_st;
	logic [WORD_WIDTH-1:0] rd_word;
	logic [WORD_WIDTH-1:0] cell_word [DEPTH];
	logic [WORD_WIDTH-1:0] cell_pick [DEPTH];

	// Handshake: a new item may enter unless a result is held back.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	// Range and capacity checks on the incoming item.
	assign pos_x       = CMPW'(req_item.position);
	assign cnt_x       = CMPW'(count_q);
	assign ins_range   = (pos_x > cnt_x);
	assign other_range = (pos_x >= cnt_x);
	assign full        = (cnt_x == CMPW'(DEPTH));
	assign word_st     = WORD_WIDTH'(req_item.word_in);

	// Decode the action into row operations and the result fields.
	always_comb begin
		ins_ok  = 1'b0;
		ers_ok  = 1'b0;
		rd_ok   = 1'b0;
		wr_ok   = 1'b0;
		rsp_nxt = '0;
		rsp_nxt.status = ST_OK;
		case (req_item.action)
			ACT_INSERT: begin
				if (ins_range) begin
					rsp_nxt.status = ST_RANGE;
				end else if (full) begin
					rsp_nxt.status = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			ACT_ERASE: begin
				if (other_range) begin
					rsp_nxt.status = ST_RANGE;
				end else begin
					ers_ok = 1'b1;
				end
			end
			ACT_READ: begin
				if (other_range) begin
					rsp_nxt.status = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			ACT_WRITE: begin
				if (other_range) begin
					rsp_nxt.status = ST_RANGE;
				end else begin
					wr_ok = 1'b1;
				end
			end
			default: begin
				rsp_nxt.status = ST_RANGE;
			end
		endcase

		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + CW'(1);
		end else if (ers_ok) begin
			count_nxt = count_q - CW'(1);
		end

		rsp_nxt.entry_count = CNT_OUT_W'(count_nxt);
		if (ers_ok || rd_ok) begin
			rsp_nxt.word_out = DATA_W'(rd_word);
		end
	end

	assign op = '{ins: accept && ins_ok, ers: accept && ers_ok, wr: accept && wr_ok};

	// The row of cells; each hands its word to both neighbours.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] prev_w;
		logic [WORD_WIDTH-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = word_st;
		end else begin : g_mid_lo
			assign prev_w = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_w = cell_word[i];
		end else begin : g_mid_hi
			assign next_w = cell_word[i+1];
		end

		ilie_cell #(
			.IDX_W      (CMPW),
			.INDEX      (i),
			.WORD_WIDTH (WORD_WIDTH)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.position  (pos_x),
			.word_in   (word_st),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (cell_word[i]),
			.pick      (cell_pick[i])
		);
	end

	// Read bus: at most one cell offers a non-zero word.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | cell_pick[i];
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_item_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	// The count never passes the capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(DEPTH))
		else $error("entry count above capacity");

	// A successful insert grows the list by one.
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list");

	// A successful erase shrinks the list by one.
	a_ers_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		op.ers |=> (count_q == $past(count_q) - CW'(1)))
		else $error("erase did not shrink the list");

	// A rejected item leaves the count alone.
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (rsp_nxt.status != ST_OK)) |=> $stable(count_q))
		else $error("rejected item changed the count");

	// Every accepted item yields a result in the next cycle.
	a_rsp_follow: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted item produced no result");

endmodule

`default_nettype wire

// ===== dv/indexed_list_insert_erase_tb.sv =====
module indexed_list_insert_erase_tb;
	import ilie_pkg::*;

	localparam int LIST_DEPTH  = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 375;

	// One row of the directed script: the item, and where it is obvious, the
	// result that it must give.
	typedef struct {
		req_item_t item;
		bit        typed;
		rsp_item_t rsp;
	} step_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_item = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp_item;

	// Shadow copy of the list, updated as each item is accepted.
	logic [31:0] held_words [LIST_DEPTH];
	int          held_count;
	rsp_item_t   pending_results [$];
	int          mismatches;
	int          cycle_cnt;

	// Sender and receiver pacing, in percent per cycle.
	int send_idle_pct;
	int stall_pct;
	int hold_req;
	int hold_left;

	// Typed expectation travelling with the item currently offered.
	bit        typed_valid;
	rsp_item_t typed_rsp;

	step_row_t script [27];

	indexed_list_insert_erase dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	always #10 clk = ~clk;

	// Apply one action to the shadow list and return the result it gives.
	function automatic rsp_item_t apply_action(req_item_t it);
		rsp_item_t r;
		int        pos;
		r = '{word_out: '0, entry_count: '0, status: ST_OK};
		pos = it.position;
		if (it.action == ACT_INSERT) begin
			if (pos > held_count) begin
				r.status = ST_RANGE;
			end else if (held_count >= LIST_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				for (int i = held_count; i > pos; i--)
					held_words[i] = held_words[i-1];
				held_words[pos] = it.word_in;
				held_count++;
			end
		end else if (pos >= held_count) begin
			r.status = ST_RANGE;
		end else if (it.action == ACT_ERASE) begin
			r.word_out = held_words[pos];
			for (int i = pos; i + 1 < held_count; i++)
				held_words[i] = held_words[i+1];
			held_count--;
		end else if (it.action == ACT_READ) begin
			r.word_out = held_words[pos];
		end else begin
			held_words[pos] = it.word_in;
		end
		r.entry_count = 5'(held_count);
		return r;
	endfunction

	// Random item biased towards inserts on a short list and erases on a long
	// one, so that the fill level wanders over the whole range.
	function automatic req_item_t pick_random_item();
		req_item_t it;
		int        r;
		int        top;
		r = $urandom_range(99);
		if (r < ((held_count < 8) ? 45 : 25))
			it.action = ACT_INSERT;
		else if (r < 65)
			it.action = ACT_ERASE;
		else if (r < 85)
			it.action = ACT_READ;
		else
			it.action = ACT_WRITE;
		top = (it.action == ACT_INSERT) ? held_count : held_count - 1;
		if ($urandom_range(9) == 0 || top < 0)
			it.position = 5'($urandom_range(31, top + 1));
		else
			it.position = 5'($urandom_range(top, 0));
		it.word_in = $urandom();
		return it;
	endfunction

	function automatic step_row_t mk(action_t a, int p, logic [31:0] w, bit t,
			status_t s, int c);
		step_row_t row;
		row.item = '{action: a, position: 5'(p), word_in: w};
		row.typed = t;
		row.rsp = '{word_out: '0, entry_count: 5'(c), status: s};
		return row;
	endfunction

	// Offer one item, idling at random beforehand; returns once it is taken.
	// A script index below zero asks for a random item.
	task automatic offer(input int idx);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle_pct) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end else begin
				break;
			end
		end
		if (idx >= 0) begin
			req_item <= script[idx].item;
			typed_valid <= script[idx].typed;
			typed_rsp <= script[idx].rsp;
		end else begin
			req_item <= pick_random_item();
			typed_valid <= 1'b0;
		end
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Check each taken result against the oldest expectation, then predict
	// the result of any item taken at the same edge.
	always @(posedge clk) begin
		rsp_item_t want;
		rsp_item_t got_pred;
		if (rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result item with no expectation waiting: %h", rsp_item);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_item.word_out !== want.word_out) begin
					$error("word_out: expected %h, got %h", want.word_out,
						rsp_item.word_out);
					mismatches++;
				end
				if (rsp_item.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						rsp_item.entry_count);
					mismatches++;
				end
				if (rsp_item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status,
						rsp_item.status);
					mismatches++;
				end
			end
		end
		if (req_valid && !req_stall) begin
			got_pred = apply_action(req_item);
			pending_results.push_back(typed_valid ? typed_rsp : got_pred);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		held_count = 0;
		mismatches = 0;
		cycle_cnt = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		typed_valid = 1'b0;
		typed_rsp = '0;
		for (int i = 0; i < LIST_DEPTH; i++)
			held_words[i] = '0;

		// Directed script: errors on the empty list, a few edits, filling up
		// to capacity, full and out-of-range inserts, and work at the top end.
		script = '{
			mk(ACT_READ,    0, 32'h0,        1, ST_RANGE, 0),
			mk(ACT_ERASE,   0, 32'h0,        1, ST_RANGE, 0),
			mk(ACT_WRITE,   0, 32'hFFFFFFFF, 1, ST_RANGE, 0),
			mk(ACT_INSERT,  1, 32'h12345678, 1, ST_RANGE, 0),
			mk(ACT_INSERT,  0, 32'hFFFFFFFF, 1, ST_OK,    1),
			mk(ACT_INSERT,  0, 32'h00000000, 1, ST_OK,    2),
			mk(ACT_READ,    1, 32'hFFFFFFFF, 0, ST_OK,    0),
			mk(ACT_WRITE,   0, 32'h5A5A5A5A, 1, ST_OK,    2),
			mk(ACT_INSERT,  2, 32'hA5A5A5A5, 0, ST_OK,    0),
			mk(ACT_INSERT,  0, 32'h00000001, 0, ST_OK,    0),
			mk(ACT_INSERT,  3, 32'h80000000, 0, ST_OK,    0),
			mk(ACT_INSERT,  1, 32'h7FFFFFFF, 0, ST_OK,    0),
			mk(ACT_INSERT,  5, 32'hDEADBEEF, 0, ST_OK,    0),
			mk(ACT_INSERT,  2, 32'h0F0F0F0F, 0, ST_OK,    0),
			mk(ACT_INSERT,  7, 32'hF0F0F0F0, 0, ST_OK,    0),
			mk(ACT_INSERT,  4, 32'h33333333, 0, ST_OK,    0),
			mk(ACT_INSERT,  9, 32'hCCCCCCCC, 0, ST_OK,    0),
			mk(ACT_INSERT,  0, 32'h55555555, 0, ST_OK,    0),
			mk(ACT_INSERT, 11, 32'hAAAAAAAA, 0, ST_OK,    0),
			mk(ACT_INSERT,  5, 32'h01234567, 0, ST_OK,    0),
			mk(ACT_INSERT, 13, 32'h89ABCDEF, 0, ST_OK,    0),
			mk(ACT_INSERT, 15, 32'hFEDCBA98, 0, ST_OK,    0),
			mk(ACT_INSERT, 16, 32'h11111111, 1, ST_FULL,  16),
			mk(ACT_INSERT, 31, 32'h22222222, 1, ST_RANGE, 16),
			mk(ACT_READ,   15, 32'h0,        0, ST_OK,    0),
			mk(ACT_ERASE,  15, 32'h0,        0, ST_OK,    0),
			mk(ACT_READ,   15, 32'h0,        1, ST_RANGE, 15)
		};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			offer(i);

		// Hold the receiver off for a long stretch while items keep coming.
		hold_req = 60;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 72; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 72; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				offer(-1);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== indexed_list_insert_erase.f =====
hw/rtl/ilie_pkg.sv
hw/rtl/ilie_cell.sv
hw/rtl/indexed_list_insert_erase.sv
dv/indexed_list_insert_erase_tb.sv
